[rtl/core/ray_triangle_intersect_unit_macros.svh]
// Assertion macros for the ray/triangle intersection unit.
// Used by the port checker; no other dependencies.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_MACROS_SVH

// clocked assertion with reset disable and a fixed message
`define RTI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rti assertion failed");

// same, with a caller-supplied message string
`define RTI_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

`endif

[rtl/core/rti_pkg.sv]
// Shared types and constants for the ray/triangle intersection unit.
// No dependencies.
`default_nettype none
package rti_pkg;

  localparam int RTI_CFG_INDEX_BITS = 2;
  localparam int RTI_CFG_DATA_BITS  = 63;
  localparam int RTI_EPS_BITS       = 16;
  localparam logic [RTI_EPS_BITS-1:0] RTI_EPS_RESET = 16'd16;
  localparam int RTI_DIST_BITS      = 32;
  localparam int RTI_QUEUE_DEPTH    = 4;

  typedef enum logic [RTI_CFG_INDEX_BITS-1:0] {
    CFG_VERTEX_A = 2'd0,
    CFG_VERTEX_B = 2'd1,
    CFG_VERTEX_C = 2'd2,
    CFG_EPSILON  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_PARALLEL = 2'd1,
    STATUS_BEHIND   = 2'd2,
    STATUS_OUTSIDE  = 2'd3
  } status_e;

endpackage
`default_nettype wire

[rtl/core/rti_interfaces.sv]
// Handshake interfaces: config writes, ray requests, results, internal stream.
// Depends on nothing.
`default_nettype none
interface rti_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [62:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface rti_ray_if #(parameter int CoordBits = 21, parameter int DirBits = 16);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] origin_x;
  logic signed [CoordBits-1:0] origin_y;
  logic signed [CoordBits-1:0] origin_z;
  logic signed [DirBits-1:0]   dir_x;
  logic signed [DirBits-1:0]   dir_y;
  logic signed [DirBits-1:0]   dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rti_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  status;
  logic [31:0] hit_distance;
  modport source (output valid, hit, status, hit_distance, input ready);
  modport sink   (input valid, hit, status, hit_distance, output ready);
endinterface

interface rti_stream_if #(parameter int Width = 1);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/rti_front.sv]
// Front end: config registers, geometry pipeline and classification.
// Depends on rti_pkg and rti_interfaces.
`default_nettype none
module rti_front #(
  parameter int COORD_BITS = 21,
  parameter int DIR_BITS   = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  rti_cfg_if.sink      cfg_i,
  rti_ray_if.sink      ray_i,
  rti_stream_if.source item_o
);
  import rti_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DB  = DIR_BITS;
  localparam int DF  = DB - 2;
  localparam int EW  = CB + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = PW + 1;
  localparam int DW  = NW + DB + 2;
  localparam int MW  = NW + EW + 2;
  localparam int NL  = NW / 2;
  localparam int NH  = NW - NL;
  localparam int NNW = 2 * NW;
  localparam int AL  = DW / 2;
  localparam int AH  = DW - AL;
  localparam int LSH = (32 > 2 * DF) ? 32 - 2 * DF : 0;
  localparam int RSH = (2 * DF > 32) ? 2 * DF - 32 : 0;
  localparam int LW  = 2 * DW + LSH;
  localparam int CK  = (NNW + 2) / 3;
  localparam int CT  = NNW - 2 * CK;
  localparam int RHW = NNW + 32 + RSH;
  localparam int CW  = (LW > RHW) ? LW : RHW;
  localparam int AW  = MW + DF;
  localparam int RW  = DW + 1;
  localparam int SW  = (AW > DW + 32) ? AW : DW + 32;

  // config registers
  logic [RTI_CFG_DATA_BITS-1:0] vtx_q [3];
  logic [RTI_EPS_BITS-1:0]      eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q[0] <= '0;
      vtx_q[1] <= '0;
      vtx_q[2] <= '0;
      eps_q    <= RTI_EPS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_VERTEX_A: vtx_q[0] <= cfg_i.data;
        CFG_VERTEX_B: vtx_q[1] <= cfg_i.data;
        CFG_VERTEX_C: vtx_q[2] <= cfg_i.data;
        CFG_EPSILON:  eps_q    <= cfg_i.data[RTI_EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v_q [1:8];

  assign en          = !v_q[8] || item_o.ready;
  assign ray_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 8; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[1] <= ray_i.valid;
      for (int i = 2; i <= 8; i++) v_q[i] <= v_q[i-1];
    end
  end

  // stage registers
  logic signed [EW-1:0] s1_e1_q [3], s1_e2_q [3];
  logic signed [EW-1:0] s1_r_q  [3][3];
  logic signed [DB-1:0] s1_d_q  [3];
  logic [31:0]          s1_eps2_q;

  logic signed [PW-1:0] s2_np_q [3], s2_nq_q [3];
  logic signed [PW-1:0] s2_cp_q [3][3], s2_cq_q [3][3];
  logic signed [DB-1:0] s2_d_q  [3];
  logic signed [EW-1:0] s2_rel_q [3];
  logic [31:0]          s2_eps2_q;

  logic signed [NW-1:0] s3_n_q  [3];
  logic signed [NW-1:0] s3_cr_q [3][3];
  logic signed [DB-1:0] s3_d_q  [3];
  logic signed [EW-1:0] s3_rel_q [3];
  logic [31:0]          s3_eps2_q;

  logic signed [NW+DB-1:0]   s4_den_q [3];
  logic signed [NW+EW-1:0]   s4_num_q [3];
  logic signed [NW+DB-1:0]   s4_det_q [3][3];
  logic signed [2*NH-1:0]    s4_hh_q [3];
  logic signed [NH+NL:0]     s4_hl_q [3];
  logic [2*NL-1:0]           s4_ll_q [3];
  logic [31:0]               s4_eps2_q;

  logic signed [DW-1:0] s5_den_q;
  logic signed [MW-1:0] s5_num_q;
  logic signed [DW-1:0] s5_det_q [3];
  logic [NNW-1:0]       s5_nnk_q [3];
  logic [31:0]          s5_eps2_q;

  logic [NNW-1:0]        s6_nn_q;
  logic [31:0]           s6_eps2_q;
  logic                  s6_out_q, s6_behind_q, s6_dz_q;
  logic signed [2*AH-1:0] s6_hh_q;
  logic signed [AH+AL:0]  s6_hl_q;
  logic [2*AL-1:0]        s6_ll_q;
  logic [AW-1:0]          s6_anum_q;
  logic [DW-1:0]          s6_aden_q;

  logic [LW-1:0]    s7_lhs_q;
  logic [CK+31:0]   s7_p0_q, s7_p1_q;
  logic [CT+31:0]   s7_p2_q;
  logic             s7_out_q, s7_behind_q, s7_dz_q, s7_sat_q;
  logic [AW-1:0]    s7_anum_q;
  logic [DW-1:0]    s7_aden_q;

  status_e          s8_st_q;
  logic             s8_sat_q;
  logic [RW-1:0]    s8_rem_q;
  logic [31:0]      s8_lo_q;
  logic [DW-1:0]    s8_aden_q;

  // combinational helpers
  logic signed [CB-1:0] vx [3][3];
  logic signed [CB-1:0] org [3];
  logic signed [DB-1:0] dir [3];
  logic signed [NH-1:0] hi_n [3];
  logic [NL-1:0]        lo_n [3];
  logic signed [AH-1:0] den_hi;
  logic [AL-1:0]        den_lo;
  logic [MW-1:0]        abs_num;
  logic [DW-1:0]        abs_den;
  logic [2*DW-1:0]      den2;
  logic [RHW-1:0]       rhs;
  logic                 is_par;
  logic                 det_pos, det_neg;

  always_comb begin
    org[0] = ray_i.origin_x;
    org[1] = ray_i.origin_y;
    org[2] = ray_i.origin_z;
    dir[0] = ray_i.dir_x;
    dir[1] = ray_i.dir_y;
    dir[2] = ray_i.dir_z;
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++)
        vx[v][k] = $signed(vtx_q[v][k*CB +: CB]);
    for (int k = 0; k < 3; k++) begin
      hi_n[k] = NH'(s3_n_q[k] >>> NL);
      lo_n[k] = s3_n_q[k][NL-1:0];
    end
    den_hi  = $signed(s5_den_q[DW-1:AL]);
    den_lo  = s5_den_q[AL-1:0];
    abs_num = s5_num_q[MW-1] ? MW'(-s5_num_q) : MW'(s5_num_q);
    abs_den = s5_den_q[DW-1] ? DW'(-s5_den_q) : DW'(s5_den_q);
    det_pos = 1'b0;
    det_neg = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (s5_det_q[j][DW-1]) det_neg = 1'b1;
      else if (s5_det_q[j] != '0) det_pos = 1'b1;
    end
    den2 = (2*DW)'(s6_hh_q) << (2 * AL);
    den2 = den2 + ((2*DW)'(s6_hl_q) << (AL + 1)) + (2*DW)'(s6_ll_q);
    rhs  = (RHW'(s7_p0_q) + (RHW'(s7_p1_q) << CK) + (RHW'(s7_p2_q) << (2 * CK))) << RSH;
    is_par = s7_dz_q || (CW'(s7_lhs_q) < CW'(rhs));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: differences
      for (int k = 0; k < 3; k++) begin
        s1_e1_q[k] <= EW'(vx[1][k]) - EW'(vx[0][k]);
        s1_e2_q[k] <= EW'(vx[2][k]) - EW'(vx[0][k]);
        s1_d_q[k]  <= dir[k];
        for (int v = 0; v < 3; v++) s1_r_q[v][k] <= EW'(vx[v][k]) - EW'(org[k]);
      end
      s1_eps2_q <= eps_q * eps_q;
      // stage 2: cross product terms
      for (int k = 0; k < 3; k++) begin
        s2_np_q[k]  <= s1_e1_q[(k+1)%3] * s1_e2_q[(k+2)%3];
        s2_nq_q[k]  <= s1_e1_q[(k+2)%3] * s1_e2_q[(k+1)%3];
        s2_d_q[k]   <= s1_d_q[k];
        s2_rel_q[k] <= s1_r_q[0][k];
        for (int j = 0; j < 3; j++) begin
          s2_cp_q[j][k] <= s1_r_q[j][(k+1)%3] * s1_r_q[(j+1)%3][(k+2)%3];
          s2_cq_q[j][k] <= s1_r_q[j][(k+2)%3] * s1_r_q[(j+1)%3][(k+1)%3];
        end
      end
      s2_eps2_q <= s1_eps2_q;
      // stage 3: cross products
      for (int k = 0; k < 3; k++) begin
        s3_n_q[k]   <= NW'(s2_np_q[k]) - NW'(s2_nq_q[k]);
        s3_d_q[k]   <= s2_d_q[k];
        s3_rel_q[k] <= s2_rel_q[k];
        for (int j = 0; j < 3; j++)
          s3_cr_q[j][k] <= NW'(s2_cp_q[j][k]) - NW'(s2_cq_q[j][k]);
      end
      s3_eps2_q <= s2_eps2_q;
      // stage 4: dot product terms
      for (int k = 0; k < 3; k++) begin
        s4_den_q[k] <= s3_n_q[k] * s3_d_q[k];
        s4_num_q[k] <= s3_n_q[k] * s3_rel_q[k];
        s4_hh_q[k]  <= hi_n[k] * hi_n[k];
        s4_hl_q[k]  <= hi_n[k] * $signed({1'b0, lo_n[k]});
        s4_ll_q[k]  <= lo_n[k] * lo_n[k];
        for (int j = 0; j < 3; j++) s4_det_q[j][k] <= s3_d_q[k] * s3_cr_q[j][k];
      end
      s4_eps2_q <= s3_eps2_q;
      // stage 5: sums
      s5_den_q <= DW'(s4_den_q[0]) + DW'(s4_den_q[1]) + DW'(s4_den_q[2]);
      s5_num_q <= MW'(s4_num_q[0]) + MW'(s4_num_q[1]) + MW'(s4_num_q[2]);
      for (int j = 0; j < 3; j++)
        s5_det_q[j] <= DW'(s4_det_q[j][0]) + DW'(s4_det_q[j][1]) + DW'(s4_det_q[j][2]);
      for (int k = 0; k < 3; k++)
        s5_nnk_q[k] <= (NNW'(s4_hh_q[k]) << (2 * NL)) + (NNW'(s4_hl_q[k]) << (NL + 1))
                       + NNW'(s4_ll_q[k]);
      s5_eps2_q <= s4_eps2_q;
      // stage 6: flags, magnitudes, den^2 terms
      s6_nn_q     <= s5_nnk_q[0] + s5_nnk_q[1] + s5_nnk_q[2];
      s6_eps2_q   <= s5_eps2_q;
      s6_out_q    <= det_pos && det_neg;
      s6_dz_q     <= (s5_den_q == '0);
      s6_behind_q <= (s5_num_q != '0) && (s5_num_q[MW-1] != s5_den_q[DW-1]);
      s6_hh_q     <= den_hi * den_hi;
      s6_hl_q     <= den_hi * $signed({1'b0, den_lo});
      s6_ll_q     <= den_lo * den_lo;
      s6_anum_q   <= AW'(abs_num) << DF;
      s6_aden_q   <= abs_den;
      // stage 7: den^2, nn * eps^2 terms, saturation
      s7_lhs_q    <= LW'(den2) << LSH;
      s7_p0_q     <= s6_nn_q[CK-1:0] * s6_eps2_q;
      s7_p1_q     <= s6_nn_q[2*CK-1:CK] * s6_eps2_q;
      s7_p2_q     <= s6_nn_q[NNW-1:2*CK] * s6_eps2_q;
      s7_out_q    <= s6_out_q;
      s7_dz_q     <= s6_dz_q;
      s7_behind_q <= s6_behind_q;
      s7_sat_q    <= SW'(s6_anum_q) >= (SW'(s6_aden_q) << 32);
      s7_anum_q   <= s6_anum_q;
      s7_aden_q   <= s6_aden_q;
      // stage 8: classification
      if (is_par)           s8_st_q <= STATUS_PARALLEL;
      else if (s7_behind_q) s8_st_q <= STATUS_BEHIND;
      else if (s7_out_q)    s8_st_q <= STATUS_OUTSIDE;
      else                  s8_st_q <= STATUS_HIT;
      s8_sat_q  <= s7_sat_q;
      s8_rem_q  <= RW'(s7_anum_q >> 32);
      s8_lo_q   <= s7_anum_q[31:0];
      s8_aden_q <= s7_aden_q;
    end
  end

  assign item_o.valid = v_q[8];
  assign item_o.data  = {s8_st_q, s8_sat_q, s8_rem_q, s8_lo_q, s8_aden_q};

endmodule
`default_nettype wire

[rtl/core/rti_queue.sv]
// Small request queue between the front end and the divider back end.
// Depends on rti_pkg and rti_interfaces.
`default_nettype none
module rti_queue #(
  parameter int WIDTH = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  rti_stream_if.sink   in_i,
  rti_stream_if.source out_o
);
  import rti_pkg::*;

  localparam int PTR_BITS = $clog2(RTI_QUEUE_DEPTH);

  logic [WIDTH-1:0]  mem_q [RTI_QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [PTR_BITS:0]   cnt_q;
  logic push, pop;

  assign in_i.ready  = (cnt_q != (PTR_BITS+1)'(RTI_QUEUE_DEPTH));
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rd_q];
  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i.data;
  end

endmodule
`default_nettype wire

[rtl/core/rti_back.sv]
// Back end: 32-stage restoring divider for the distance and the result register.
// Depends on rti_pkg and rti_interfaces.
`default_nettype none
module rti_back #(
  parameter int COORD_BITS = 21,
  parameter int DIR_BITS   = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  rti_stream_if.sink   item_i,
  rti_res_if.source    res_o
);
  import rti_pkg::*;

  localparam int EW = COORD_BITS + 1;
  localparam int NW = 2 * EW + 1;
  localparam int DW = NW + DIR_BITS + 2;
  localparam int RW = DW + 1;
  localparam int NS = RTI_DIST_BITS;

  function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic b, logic [DW-1:0] d);
    logic [RW-1:0] t;
    logic [RW-1:0] dd;
    t  = {rem[RW-2:0], b};
    dd = {1'b0, d};
    if (t >= dd) return {1'b1, t - dd};
    return {1'b0, t};
  endfunction

  logic          en;
  logic          v_q   [NS];
  logic [1:0]    st_q  [NS];
  logic          sat_q [NS];
  logic [RW-1:0] rem_q [NS];
  logic [NS-1:0] lo_q  [NS];
  logic [NS-1:0] quo_q [NS];
  logic [DW-1:0] den_q [NS];

  logic          res_v_q, hit_q;
  logic [1:0]    res_st_q;
  logic [NS-1:0] dist_q;
  logic [RW:0]   stp [NS];

  assign en           = !res_v_q || res_o.ready;
  assign item_i.ready = en;

  always_comb begin
    for (int j = 0; j < NS; j++) stp[j] = div_step(rem_q[j], lo_q[j][NS-1], den_q[j]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) v_q[j] <= 1'b0;
      res_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= item_i.valid;
      for (int j = 1; j < NS; j++) v_q[j] <= v_q[j-1];
      res_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      {st_q[0], sat_q[0], rem_q[0], lo_q[0], den_q[0]} <= item_i.data;
      quo_q[0] <= '0;
      for (int j = 1; j < NS; j++) begin
        st_q[j]  <= st_q[j-1];
        sat_q[j] <= sat_q[j-1];
        den_q[j] <= den_q[j-1];
        rem_q[j] <= stp[j-1][RW-1:0];
        lo_q[j]  <= {lo_q[j-1][NS-2:0], 1'b0};
        quo_q[j] <= {quo_q[j-1][NS-2:0], stp[j-1][RW]};
      end
      hit_q    <= (st_q[NS-1] == STATUS_HIT);
      res_st_q <= st_q[NS-1];
      if (st_q[NS-1] != STATUS_HIT) dist_q <= '0;
      else if (sat_q[NS-1])         dist_q <= '1;
      else                          dist_q <= {quo_q[NS-1][NS-2:0], stp[NS-1][RW]};
    end
  end

  assign res_o.valid        = res_v_q;
  assign res_o.hit          = hit_q;
  assign res_o.status       = res_st_q;
  assign res_o.hit_distance = dist_q;

endmodule
`default_nettype wire

[rtl/core/ray_triangle_intersect_unit.sv]
// Ray versus single-triangle intersection unit: one ray request per cycle while
// the pipeline is not stalled, one result per ray in order. A ray passes the
// geometry and classification stages, the queue, the restoring divider (one
// quotient bit per stage) and the result register; the multiplier stages and
// the divider are fully pipelined, so throughput stays at one ray per cycle
// whenever the result side takes results. Config writes are always taken and
// apply to rays accepted from the following cycle on.
`default_nettype none
module ray_triangle_intersect_unit #(
  parameter int COORD_BITS = 21,
  parameter int DIR_BITS   = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  rti_cfg_if.sink   cfg_i,
  rti_ray_if.sink   ray_i,
  rti_res_if.source res_o
);
  localparam int EW = COORD_BITS + 1;
  localparam int NW = 2 * EW + 1;
  localparam int DW = NW + DIR_BITS + 2;
  localparam int QW = 2 + 1 + (DW + 1) + 32 + DW;

  rti_stream_if #(.Width(QW)) front_q ();
  rti_stream_if #(.Width(QW)) q_back ();

  rti_front #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .ray_i  (ray_i),
    .item_o (front_q)
  );

  rti_queue #(.WIDTH(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_q),
    .out_o  (q_back)
  );

  rti_back #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (q_back),
    .res_o  (res_o)
  );

endmodule
`default_nettype wire

[rtl/core/rti_checker.sv]
// Port-level checker for the intersection unit, bound to the top level.
// Depends on rti_pkg and the assertion macro header.
`default_nettype none
`include "ray_triangle_intersect_unit_macros.svh"
module rti_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        res_valid_i,
  input wire        res_ready_i,
  input wire        hit_i,
  input wire [1:0]  status_i,
  input wire [31:0] dist_i,
  input wire        cfg_ready_i
);
  import rti_pkg::*;

  `RTI_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i) && $stable(dist_i))
  `RTI_ASSERT_MSG(a_hit_status, clk_i, rst_ni, res_valid_i |-> (hit_i == (status_i == STATUS_HIT)), "hit disagrees with status")
  `RTI_ASSERT_MSG(a_miss_dist, clk_i, rst_ni, res_valid_i && !hit_i |-> dist_i == 32'd0, "distance on a miss")
  `RTI_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_i)

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .hit_i       (res_o.hit),
  .status_i    (res_o.status),
  .dist_i      (res_o.hit_distance),
  .cfg_ready_i (cfg_i.ready)
);
`default_nettype wire
